FILE: rtl/nvb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvb_pkg
// Shared constants and rounding helpers for the ned to body direction pipeline.
// ----------------------------------------------------------------------------
package nvb_pkg;

    // phases carry 2^32 per turn plus headroom for the cordic accumulators
    localparam int PHASE_W = 34;
    // sine / cosine in q30, with a sign bit and margin
    localparam int SC_W = 32;
    // q30 product width after rounding
    localparam int Q_W = 33;
    // matrix entry width in q28
    localparam int E_W = 32;
    localparam int ATAN_LEN = 24;

    localparam logic signed [PHASE_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [20:0] GAIN_Q20 = 21'sd636751;

    function automatic logic signed [PHASE_W-1:0] atan_phase(input int idx);
        logic signed [PHASE_W-1:0] val;
        case (idx)
            0: val = 34'sd536870912;
            1: val = 34'sd316933406;
            2: val = 34'sd167458907;
            3: val = 34'sd85004756;
            4: val = 34'sd42667331;
            5: val = 34'sd21354465;
            6: val = 34'sd10679838;
            7: val = 34'sd5340245;
            8: val = 34'sd2670163;
            9: val = 34'sd1335087;
            10: val = 34'sd667544;
            11: val = 34'sd333772;
            12: val = 34'sd166886;
            13: val = 34'sd83443;
            14: val = 34'sd41722;
            15: val = 34'sd20861;
            16: val = 34'sd10430;
            17: val = 34'sd5215;
            18: val = 34'sd2608;
            19: val = 34'sd1304;
            20: val = 34'sd652;
            21: val = 34'sd326;
            22: val = 34'sd163;
            23: val = 34'sd81;
            default: val = '0;
        endcase
        return val;
    endfunction

    // round a q60 product back to q30
    function automatic logic signed [Q_W-1:0] q30_round(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + (66'sd1 <<< 29);
        return t[62:30];
    endfunction

    // round a q30 entry to q28
    function automatic logic signed [E_W-1:0] q28_round(input logic signed [Q_W:0] v);
        logic signed [Q_W:0] t;
        t = v + 34'sd2;
        return t[Q_W:2];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/nvb_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvb_delay
// Enabled shift line that keeps side data in step with the datapath stages.
// ----------------------------------------------------------------------------
module nvb_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] dly_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/nvb_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvb_sincos
// Pipelined rotation cordic: binary angle in, q30 sine and cosine out.
// ----------------------------------------------------------------------------
module nvb_sincos #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [ANGLE_BITS-1:0]        angle,
    output logic signed [nvb_pkg::SC_W-1:0]   sin_val,
    output logic signed [nvb_pkg::SC_W-1:0]   cos_val
);
    import nvb_pkg::*;

    logic signed [PHASE_W-1:0] x_reg [1:CORDIC_STEPS];
    logic signed [PHASE_W-1:0] y_reg [1:CORDIC_STEPS];
    logic signed [PHASE_W-1:0] z_reg [0:CORDIC_STEPS];
    logic                      flip_reg [0:CORDIC_STEPS];
    logic signed [SC_W-1:0]    sin_reg;
    logic signed [SC_W-1:0]    cos_reg;

    logic [31:0] phase;
    logic [31:0] phase_q;
    logic [31:0] phase_f;
    logic        flip_next;

    always_comb
    begin
        phase     = {angle, {(32-ANGLE_BITS){1'b0}}};
        phase_q   = phase + 32'h4000_0000;
        flip_next = phase_q[31];
        // second and third quadrants fold by half a turn
        phase_f   = flip_next ? (phase ^ 32'h8000_0000) : phase;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]    <= {{(PHASE_W-32){phase_f[31]}}, phase_f};
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [PHASE_W-1:0] xs;
        logic signed [PHASE_W-1:0] ys;
        logic signed [PHASE_W-1:0] x_next;
        logic signed [PHASE_W-1:0] y_next;
        logic signed [PHASE_W-1:0] z_next;

        if (k == 0)
        begin : g_first
            assign xs = GAIN_Q30;
            assign ys = '0;
        end
        else
        begin : g_rest
            assign xs = x_reg[k];
            assign ys = y_reg[k];
        end

        always_comb
        begin
            if (!z_reg[k][PHASE_W-1])
            begin
                x_next = xs - (ys >>> k);
                y_next = ys + (xs >>> k);
                z_next = z_reg[k] - atan_phase(k);
            end
            else
            begin
                x_next = xs + (ys >>> k);
                y_next = ys - (xs >>> k);
                z_next = z_reg[k] + atan_phase(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    logic signed [PHASE_W-1:0] cos_next;
    logic signed [PHASE_W-1:0] sin_next;

    always_comb
    begin
        cos_next = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        sin_next = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next[SC_W-1:0];
            sin_reg <= sin_next[SC_W-1:0];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule
`default_nettype wire

FILE: rtl/nvb_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvb_matrix
// Builds the yaw-pitch-roll matrix, rotates the vector into body axes and
// flags short vectors or ones that do not point forward. Six register stages.
// ----------------------------------------------------------------------------
module nvb_matrix #(
    parameter int VECTOR_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [nvb_pkg::SC_W-1:0]    sy,
    input  wire logic signed [nvb_pkg::SC_W-1:0]    cy,
    input  wire logic signed [nvb_pkg::SC_W-1:0]    sp,
    input  wire logic signed [nvb_pkg::SC_W-1:0]    cp,
    input  wire logic signed [nvb_pkg::SC_W-1:0]    sr,
    input  wire logic signed [nvb_pkg::SC_W-1:0]    cr,
    input  wire logic signed [VECTOR_BITS-1:0]      n_in,
    input  wire logic signed [VECTOR_BITS-1:0]      e_in,
    input  wire logic signed [VECTOR_BITS-1:0]      d_in,
    input  wire logic [VECTOR_BITS-2:0]             min_length,
    output logic signed [VECTOR_BITS+13:0]          fwd,
    output logic signed [VECTOR_BITS+13:0]          rgt,
    output logic signed [VECTOR_BITS+13:0]          dwn,
    output logic                                    reject
);
    import nvb_pkg::*;

    localparam int VB = VECTOR_BITS;
    localparam int SQ_W = 2 * VB + 1;
    localparam int PW = E_W + VB;
    localparam int BW = VB + 14;

    // stage 1: first level products and squares
    logic signed [63:0] cycp1_reg, sycp1_reg, cysp1_reg, sysp1_reg, sycr1_reg;
    logic signed [63:0] cycr1_reg, cpsr1_reg, cpcr1_reg, sysr1_reg, cysr1_reg;
    logic signed [SC_W-1:0] sp1_reg, sr1_reg, cr1_reg;
    logic signed [2*VB-1:0] nn1_reg, ee1_reg, dd1_reg;
    logic signed [VB-1:0] n1_reg, e1_reg, d1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycp1_reg <= cy * cp;
            sycp1_reg <= sy * cp;
            cysp1_reg <= cy * sp;
            sysp1_reg <= sy * sp;
            sycr1_reg <= sy * cr;
            cycr1_reg <= cy * cr;
            cpsr1_reg <= cp * sr;
            cpcr1_reg <= cp * cr;
            sysr1_reg <= sy * sr;
            cysr1_reg <= cy * sr;
            sp1_reg   <= sp;
            sr1_reg   <= sr;
            cr1_reg   <= cr;
            nn1_reg   <= n_in * n_in;
            ee1_reg   <= e_in * e_in;
            dd1_reg   <= d_in * d_in;
            n1_reg    <= n_in;
            e1_reg    <= e_in;
            d1_reg    <= d_in;
        end
    end

    // stage 2: round products, length test
    logic signed [Q_W-1:0] cycp2_reg, sycp2_reg, cysp2_reg, sysp2_reg, sycr2_reg;
    logic signed [Q_W-1:0] cycr2_reg, cpsr2_reg, cpcr2_reg, sysr2_reg, cysr2_reg;
    logic signed [SC_W-1:0] sp2_reg, sr2_reg, cr2_reg;
    logic signed [VB-1:0] n2_reg, e2_reg, d2_reg;
    logic short2_reg;

    logic [SQ_W-1:0] sq_sum;
    logic [SQ_W-1:0] lim_sq;

    always_comb
    begin
        sq_sum = {1'b0, nn1_reg} + {1'b0, ee1_reg} + {1'b0, dd1_reg};
        lim_sq = SQ_W'(min_length) * SQ_W'(min_length);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycp2_reg  <= q30_round(66'(cycp1_reg));
            sycp2_reg  <= q30_round(66'(sycp1_reg));
            cysp2_reg  <= q30_round(66'(cysp1_reg));
            sysp2_reg  <= q30_round(66'(sysp1_reg));
            sycr2_reg  <= q30_round(66'(sycr1_reg));
            cycr2_reg  <= q30_round(66'(cycr1_reg));
            cpsr2_reg  <= q30_round(66'(cpsr1_reg));
            cpcr2_reg  <= q30_round(66'(cpcr1_reg));
            sysr2_reg  <= q30_round(66'(sysr1_reg));
            cysr2_reg  <= q30_round(66'(cysr1_reg));
            sp2_reg    <= sp1_reg;
            sr2_reg    <= sr1_reg;
            cr2_reg    <= cr1_reg;
            n2_reg     <= n1_reg;
            e2_reg     <= e1_reg;
            d2_reg     <= d1_reg;
            short2_reg <= (sq_sum <= lim_sq);
        end
    end

    // stage 3: second level products
    logic signed [64:0] cyspsr3_reg, syspsr3_reg, cyspcr3_reg, syspcr3_reg;
    logic signed [Q_W-1:0] cycp3_reg, sycp3_reg, sycr3_reg, cycr3_reg;
    logic signed [Q_W-1:0] cpsr3_reg, cpcr3_reg, sysr3_reg, cysr3_reg;
    logic signed [SC_W-1:0] sp3_reg;
    logic signed [VB-1:0] n3_reg, e3_reg, d3_reg;
    logic short3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cyspsr3_reg <= cysp2_reg * sr2_reg;
            syspsr3_reg <= sysp2_reg * sr2_reg;
            cyspcr3_reg <= cysp2_reg * cr2_reg;
            syspcr3_reg <= sysp2_reg * cr2_reg;
            cycp3_reg   <= cycp2_reg;
            sycp3_reg   <= sycp2_reg;
            sycr3_reg   <= sycr2_reg;
            cycr3_reg   <= cycr2_reg;
            cpsr3_reg   <= cpsr2_reg;
            cpcr3_reg   <= cpcr2_reg;
            sysr3_reg   <= sysr2_reg;
            cysr3_reg   <= cysr2_reg;
            sp3_reg     <= sp2_reg;
            n3_reg      <= n2_reg;
            e3_reg      <= e2_reg;
            d3_reg      <= d2_reg;
            short3_reg  <= short2_reg;
        end
    end

    // stage 4: matrix entries in q28
    logic signed [E_W-1:0] fa4_reg, fb4_reg, fc4_reg;
    logic signed [E_W-1:0] ra4_reg, rb4_reg, rc4_reg;
    logic signed [E_W-1:0] da4_reg, db4_reg, dc4_reg;
    logic signed [VB-1:0] n4_reg, e4_reg, d4_reg;
    logic short4_reg;

    logic signed [Q_W:0] ra_q30, rb_q30, da_q30, db_q30;

    always_comb
    begin
        ra_q30 = (Q_W+1)'(q30_round(66'(cyspsr3_reg))) - (Q_W+1)'(sycr3_reg);
        rb_q30 = (Q_W+1)'(q30_round(66'(syspsr3_reg))) + (Q_W+1)'(cycr3_reg);
        da_q30 = (Q_W+1)'(q30_round(66'(cyspcr3_reg))) + (Q_W+1)'(sysr3_reg);
        db_q30 = (Q_W+1)'(q30_round(66'(syspcr3_reg))) - (Q_W+1)'(cysr3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa4_reg    <= q28_round((Q_W+1)'(cycp3_reg));
            fb4_reg    <= q28_round((Q_W+1)'(sycp3_reg));
            fc4_reg    <= q28_round(-((Q_W+1)'(sp3_reg)));
            ra4_reg    <= q28_round(ra_q30);
            rb4_reg    <= q28_round(rb_q30);
            rc4_reg    <= q28_round((Q_W+1)'(cpsr3_reg));
            da4_reg    <= q28_round(da_q30);
            db4_reg    <= q28_round(db_q30);
            dc4_reg    <= q28_round((Q_W+1)'(cpcr3_reg));
            n4_reg     <= n3_reg;
            e4_reg     <= e3_reg;
            d4_reg     <= d3_reg;
            short4_reg <= short3_reg;
        end
    end

    // stage 5: entry times component
    logic signed [PW-1:0] fn5_reg, fe5_reg, fd5_reg;
    logic signed [PW-1:0] rn5_reg, re5_reg, rd5_reg;
    logic signed [PW-1:0] dn5_reg, de5_reg, dd5_reg;
    logic short5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fn5_reg    <= fa4_reg * n4_reg;
            fe5_reg    <= fb4_reg * e4_reg;
            fd5_reg    <= fc4_reg * d4_reg;
            rn5_reg    <= ra4_reg * n4_reg;
            re5_reg    <= rb4_reg * e4_reg;
            rd5_reg    <= rc4_reg * d4_reg;
            dn5_reg    <= da4_reg * n4_reg;
            de5_reg    <= db4_reg * e4_reg;
            dd5_reg    <= dc4_reg * d4_reg;
            short5_reg <= short4_reg;
        end
    end

    // stage 6: row sums rounded to 1/256
    logic signed [PW+1:0] fsum, rsum, dsum;
    logic signed [BW-1:0] fwd_next, rgt_next, dwn_next;
    logic signed [BW-1:0] fwd_reg, rgt_reg, dwn_reg;
    logic reject_reg;

    always_comb
    begin
        fsum = (PW+2)'(fn5_reg) + (PW+2)'(fe5_reg) + (PW+2)'(fd5_reg) + (PW+2)'(1 <<< 19);
        rsum = (PW+2)'(rn5_reg) + (PW+2)'(re5_reg) + (PW+2)'(rd5_reg) + (PW+2)'(1 <<< 19);
        dsum = (PW+2)'(dn5_reg) + (PW+2)'(de5_reg) + (PW+2)'(dd5_reg) + (PW+2)'(1 <<< 19);
        fwd_next = fsum[PW+1:20];
        rgt_next = rsum[PW+1:20];
        dwn_next = dsum[PW+1:20];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd_reg    <= fwd_next;
            rgt_reg    <= rgt_next;
            dwn_reg    <= dwn_next;
            reject_reg <= short5_reg | fwd_next[BW-1] | (fwd_next == '0);
        end
    end

    assign fwd    = fwd_reg;
    assign rgt    = rgt_reg;
    assign dwn    = dwn_reg;
    assign reject = reject_reg;

endmodule
`default_nettype wire

FILE: rtl/nvb_vector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvb_vector
// Pipelined vectoring cordic: phase and scaled magnitude of (x, y).
// ----------------------------------------------------------------------------
module nvb_vector #(
    parameter int WIDTH        = 40,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [WIDTH-1:0]           x_in,
    input  wire logic signed [WIDTH-1:0]           y_in,
    output logic signed [nvb_pkg::PHASE_W-1:0]     phase,
    output logic signed [WIDTH-1:0]                mag
);
    import nvb_pkg::*;

    logic signed [WIDTH-1:0]   x_reg [1:CORDIC_STEPS];
    logic signed [WIDTH-1:0]   y_reg [1:CORDIC_STEPS];
    logic signed [PHASE_W-1:0] z_reg [1:CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [WIDTH-1:0]   xs;
        logic signed [WIDTH-1:0]   ys;
        logic signed [PHASE_W-1:0] zs;
        logic signed [WIDTH-1:0]   x_next;
        logic signed [WIDTH-1:0]   y_next;
        logic signed [PHASE_W-1:0] z_next;

        if (k == 0)
        begin : g_first
            assign xs = x_in;
            assign ys = y_in;
            assign zs = '0;
        end
        else
        begin : g_rest
            assign xs = x_reg[k];
            assign ys = y_reg[k];
            assign zs = z_reg[k];
        end

        always_comb
        begin
            // turn toward y = 0, strictly positive y rotates clockwise
            if (ys > 0)
            begin
                x_next = xs + (ys >>> k);
                y_next = ys - (xs >>> k);
                z_next = zs + atan_phase(k);
            end
            else
            begin
                x_next = xs - (ys >>> k);
                y_next = ys + (xs >>> k);
                z_next = zs - atan_phase(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1] <= x_next;
                y_reg[k+1] <= y_next;
                z_reg[k+1] <= z_next;
            end
        end
    end

    assign phase = z_reg[CORDIC_STEPS];
    assign mag   = x_reg[CORDIC_STEPS];

endmodule
`default_nettype wire

FILE: rtl/ned_vector_to_body_azimuth_elevation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ned_vector_to_body_azimuth_elevation
// Rotates a north/east/down vector into body axes and returns its azimuth
// and elevation as binary angles with a valid flag.
//
// channel   dir  handshake             word
// s_*       in   s_tvalid / s_tready   yaw, pitch, roll, north, east, down
// m_*       out  m_tvalid / m_tready   azimuth, elevation, direction_valid
// cfg_*     in   cfg_valid / cfg_ready min_length
//
// one word enters every cycle while the output word is not held.
// stages: sin/cos cordic (steps+2), matrix and rotation (6), azimuth cordic
// (steps), hypot multiply (2), elevation cordic (steps), output rounding (1).
// the whole pipe holds while the output word waits; s_tready follows that.
// reset clears the valid line and sets min_length to 26.
// ----------------------------------------------------------------------------
module ned_vector_to_body_azimuth_elevation #(
    parameter int ANGLE_BITS   = 16,
    parameter int VECTOR_BITS  = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // yaw_angle, pitch_angle, roll_angle, north_part, east_part, down_part
    input  wire logic [((3*ANGLE_BITS+3*VECTOR_BITS+7)/8)*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // azimuth_angle, elevation_angle, direction_valid
    output logic [((2*ANGLE_BITS+1+7)/8)*8-1:0] m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [VECTOR_BITS-2:0] cfg_data
);
    import nvb_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int VB = VECTOR_BITS;
    localparam int BW = VB + 14;
    localparam int CW = VB + 16;
    localparam int HW = CW + 21;
    localparam int LATENCY = 3 * CORDIC_STEPS + 11;
    localparam int OUT_W = ((2 * AB + 1 + 7) / 8) * 8;
    localparam logic [VB-2:0] MIN_LENGTH_RESET = 26;

    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    logic [VB-2:0] min_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            min_length_reg <= cfg_data;
        end
    end

    // valid bit of every slot in the pipe
    logic valid_out;
    nvb_delay #(.WIDTH(1), .DEPTH(LATENCY)) u_valid (
        .clk(clk), .rst_n(rst_n), .en(en),
        .din(s_tvalid & en), .dout(valid_out)
    );
    assign m_tvalid = valid_out;

    logic signed [SC_W-1:0] sy, cy, sp, cp, sr, cr;

    nvb_sincos #(.ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk(clk), .en(en), .angle(s_tdata[AB-1:0]), .sin_val(sy), .cos_val(cy)
    );
    nvb_sincos #(.ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .en(en), .angle(s_tdata[2*AB-1:AB]), .sin_val(sp), .cos_val(cp)
    );
    nvb_sincos #(.ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .en(en), .angle(s_tdata[3*AB-1:2*AB]), .sin_val(sr), .cos_val(cr)
    );

    logic [3*VB-1:0] ned_dly;
    nvb_delay #(.WIDTH(3*VB), .DEPTH(CORDIC_STEPS+2)) u_ned (
        .clk(clk), .rst_n(rst_n), .en(en),
        .din(s_tdata[3*AB+3*VB-1:3*AB]), .dout(ned_dly)
    );

    logic signed [BW-1:0] fwd, rgt, dwn;
    logic reject;

    nvb_matrix #(.VECTOR_BITS(VB)) u_matrix (
        .clk(clk), .en(en),
        .sy(sy), .cy(cy), .sp(sp), .cp(cp), .sr(sr), .cr(cr),
        .n_in($signed(ned_dly[VB-1:0])),
        .e_in($signed(ned_dly[2*VB-1:VB])),
        .d_in($signed(ned_dly[3*VB-1:2*VB])),
        .min_length(min_length_reg),
        .fwd(fwd), .rgt(rgt), .dwn(dwn), .reject(reject)
    );

    logic signed [PHASE_W-1:0] az_phase;
    logic signed [CW-1:0]      az_mag;

    nvb_vector #(.WIDTH(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_azimuth (
        .clk(clk), .en(en),
        .x_in(CW'(fwd)), .y_in(CW'(rgt)),
        .phase(az_phase), .mag(az_mag)
    );

    logic [BW-1:0] dwn_dly;
    nvb_delay #(.WIDTH(BW), .DEPTH(CORDIC_STEPS+1)) u_dwn (
        .clk(clk), .rst_n(rst_n), .en(en), .din(dwn), .dout(dwn_dly)
    );

    // hypot: undo the cordic gain
    logic signed [HW-1:0] hprod_reg;
    logic signed [CW-1:0] hyp_reg;
    logic signed [CW-1:0] ndwn_reg;
    logic signed [HW-1:0] hround;

    assign hround = hprod_reg + HW'(1 <<< 19);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hprod_reg <= az_mag * GAIN_Q20;
            hyp_reg   <= hround[CW+19:20];
            ndwn_reg  <= -(CW'($signed(dwn_dly)));
        end
    end

    logic signed [PHASE_W-1:0] el_phase;
    logic signed [CW-1:0]      el_mag;

    nvb_vector #(.WIDTH(CW), .CORDIC_STEPS(CORDIC_STEPS)) u_elevation (
        .clk(clk), .en(en),
        .x_in(hyp_reg), .y_in(ndwn_reg),
        .phase(el_phase), .mag(el_mag)
    );

    logic [PHASE_W-1:0] az_dly;
    nvb_delay #(.WIDTH(PHASE_W), .DEPTH(CORDIC_STEPS+2)) u_az (
        .clk(clk), .rst_n(rst_n), .en(en), .din(az_phase), .dout(az_dly)
    );

    logic reject_dly;
    nvb_delay #(.WIDTH(1), .DEPTH(2*CORDIC_STEPS+2)) u_reject (
        .clk(clk), .rst_n(rst_n), .en(en), .din(reject), .dout(reject_dly)
    );

    // round phase to the output angle and clamp to a quarter turn
    localparam logic signed [PHASE_W-1:0] ROUND_C = PHASE_W'(1) <<< (31 - AB);
    localparam logic signed [PHASE_W-1:0] LIM = PHASE_W'(1) <<< (AB - 2);

    logic signed [PHASE_W-1:0] az_r, el_r, az_s, el_s;

    always_comb
    begin
        az_r = ($signed(az_dly) + ROUND_C) >>> (32 - AB);
        el_r = (el_phase + ROUND_C) >>> (32 - AB);
        az_s = (az_r > LIM) ? LIM : ((az_r < -LIM) ? -LIM : az_r);
        el_s = (el_r > LIM) ? LIM : ((el_r < -LIM) ? -LIM : el_r);
    end

    logic [AB-1:0] az_reg, el_reg;
    logic          dv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg <= reject_dly ? '0 : az_s[AB-1:0];
            el_reg <= reject_dly ? '0 : el_s[AB-1:0];
            dv_reg <= !reject_dly;
        end
    end

    assign m_tdata = OUT_W'({dv_reg, el_reg, az_reg});

endmodule
`default_nettype wire
